// ----- design/fdfa_pkg.sv -----
// Shared constants, field widths and command codes for the fractional-delay
// delay-and-sum block. No dependencies; every other design file imports it.
package fdfa_pkg;

   localparam int TAPS_DEF      = 11;
   localparam int OUT_DEPTH_DEF = 65536;

   localparam int CMD_W      = 2;
   localparam int TAP_IDX_W  = 4;
   localparam int COEF_W     = 18;
   localparam int SMP_W      = 16;
   localparam int RD_ADDR_W  = 16;
   localparam int VAL_W      = 32;
   localparam int DELAY_W    = 16;
   localparam int OLEN_W     = 17;
   localparam int CNT_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int FRAC_SHIFT = 16;

   localparam logic [OLEN_W-1:0] OLEN_RESET = OLEN_W'(65536);
   localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY  = 2'd0,
      CSR_OUTLEN = 2'd1
   } csr_idx_type;

endpackage

// ----- design/fdfa_if.sv -----
// Valid/ready channel interfaces for the delay-and-sum block: command input,
// read response output and register write port. Depends on fdfa_pkg.
interface fdfa_req_if;
   import fdfa_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CMD_W-1:0]            command;
   logic [TAP_IDX_W-1:0]        tap_index;
   logic signed [COEF_W-1:0]    tap_value;
   logic signed [SMP_W-1:0]     sample_value;
   logic                        restart;
   logic [RD_ADDR_W-1:0]        read_address;

   modport source (output valid, command, tap_index, tap_value, sample_value, restart,
                   read_address, input ready);
   modport sink   (input valid, command, tap_index, tap_value, sample_value, restart,
                   read_address, output ready);
endinterface

interface fdfa_rsp_if;
   import fdfa_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [VAL_W-1:0]     read_value;

   modport source (output valid, read_value, input ready);
   modport sink   (input valid, read_value, output ready);
endinterface

interface fdfa_csr_if;
   import fdfa_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CSR_IDX_W-1:0]        index;
   logic [CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/fractional_delay_fir_accumulate.sv -----
// Top level of the fractional-delay delay-and-sum accumulator.
// Depends on fdfa_pkg, fdfa_if, fdfa_mac and fdfa_rsp_queue.
//
// Delay-and-sum accumulator. Command beats load coefficients (signed Q1.16), push
// Q15 samples into a TAPS-deep delay line, or read one 32-bit output entry. Once a
// pass has pushed TAPS samples, every push forms a window whose tap sum, divided by
// 2^16 with rounding toward minus infinity, is added with signed saturation to the
// entry at window start plus delay_samples, if that entry lies below output_length
// and OUT_DEPTH. A read at or beyond OUT_DEPTH returns zero. While ready is high the
// block takes one command beat per clock. A push reaches the accumulation memory
// through a multiplier stage, a registered adder tree of clog2(TAPS) levels and an
// add and write-back step; a read response passes through the same stages, is
// then offered from a small queue and waits there when the response side stalls.
// The queue depth bounds the reads in flight, so a long response stall eventually
// drops ready. After reset the block sweeps all OUT_DEPTH entries, one entry per
// cycle, to zero the accumulation memory; ready stays low during that sweep while
// register writes are still taken. Register writes are meant for idle periods only.
module fractional_delay_fir_accumulate #(
   parameter int TAPS      = fdfa_pkg::TAPS_DEF,
   parameter int OUT_DEPTH = fdfa_pkg::OUT_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   fdfa_req_if.sink      req_ch,
   fdfa_rsp_if.source    rsp_ch,
   fdfa_csr_if.sink      csr_ch
);
   import fdfa_pkg::*;

   localparam int LEVELS = $clog2(TAPS);
   localparam int AW     = $clog2(OUT_DEPTH);
   localparam int PIPE   = LEVELS + 2;        // stages behind the accept register
   localparam int R_ST   = LEVELS;            // memory read issued here
   localparam int W_ST   = LEVELS + 1;        // tree root and read data meet here
   localparam int ACC_W  = SMP_W + COEF_W + LEVELS;
   localparam int SC_W   = ACC_W - FRAC_SHIFT;
   localparam int TGT_W  = CNT_W + 1;
   localparam int CMP_W  = (TGT_W > AW + 1) ? TGT_W : AW + 1;
   localparam int QDEPTH = 1 << $clog2(LEVELS + 4);
   localparam int CRD_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic          acc;     // accumulate into addr
      logic          rd;      // read command, gives a response
      logic          rd_ok;   // read address lies inside the memory
      logic [AW-1:0] addr;
   } ctl_type;

   // ---------------------------------------------------------------------------
   // Handshakes and command decode
   // ---------------------------------------------------------------------------
   logic in_ready, req_fire, csr_fire;
   logic is_load, is_push, is_read;

   assign req_fire = req_ch.valid && in_ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign is_load  = (req_ch.command == CMD_LOAD);
   assign is_push  = (req_ch.command == CMD_PUSH);
   assign is_read  = (req_ch.command == CMD_READ);

   assign req_ch.ready = in_ready;
   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [OLEN_W-1:0]  olen_ff, olen_in;

   always_comb begin
      delay_in = delay_ff;
      olen_in  = olen_ff;
      if (csr_fire) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_DELAY:  delay_in = csr_ch.data[DELAY_W-1:0];
            CSR_OUTLEN: olen_in  = csr_ch.data[OLEN_W-1:0];
            default:    ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         olen_ff  <= OLEN_RESET;
      end else begin
         delay_ff <= delay_in;
         olen_ff  <= olen_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Coefficient table, delay line and pass counter
   // ---------------------------------------------------------------------------
   logic signed [SMP_W-1:0]  window_ff [TAPS];
   logic signed [SMP_W-1:0]  window_in [TAPS];
   logic signed [COEF_W-1:0] taps_ff [TAPS];
   logic signed [COEF_W-1:0] taps_in [TAPS];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cnt_base, cnt_next, start;
   logic                     was_max;
   logic [TGT_W-1:0]         target;
   logic                     tgt_ok, acc_go;

   always_comb begin
      // restart clears the counter before this sample counts
      cnt_base = req_ch.restart ? '0 : count_ff;
      was_max  = (cnt_base == CNT_MAX);
      cnt_next = cnt_base + 1'b1;
      start    = cnt_next - CNT_W'(TAPS);
      target   = TGT_W'(start) + TGT_W'(delay_ff);
      tgt_ok   = (CMP_W'(target) < CMP_W'(olen_ff)) &&
                 (CMP_W'(target) < CMP_W'(OUT_DEPTH));
      acc_go   = req_fire && is_push && !was_max &&
                 (cnt_next >= CNT_W'(TAPS)) && tgt_ok;

      count_in = count_ff;
      if (req_fire && is_push) begin
         // hold at the maximum until a restart
         count_in = was_max ? cnt_base : cnt_next;
      end

      for (int j = 0; j < TAPS; j++) begin
         window_in[j] = window_ff[j];
         taps_in[j]   = taps_ff[j];
      end
      if (req_fire && is_push) begin
         for (int j = 0; j < TAPS - 1; j++) begin
            window_in[j] = window_ff[j+1];
         end
         window_in[TAPS-1] = req_ch.sample_value;
      end
      if (req_fire && is_load) begin
         // an index at or beyond TAPS matches no entry and is dropped
         for (int j = 0; j < TAPS; j++) begin
            if (int'(req_ch.tap_index) == j) begin
               taps_in[j] = req_ch.tap_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int j = 0; j < TAPS; j++) begin
            window_ff[j] <= '0;
            taps_ff[j]   <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int j = 0; j < TAPS; j++) begin
            window_ff[j] <= window_in[j];
            taps_ff[j]   <= taps_in[j];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Window sum: products of the registered window, then the adder tree
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] root;

   fdfa_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock  (clock),
      .window (window_ff),
      .taps   (taps_ff),
      .root   (root)
   );

   // ---------------------------------------------------------------------------
   // Control pipeline, kept in step with the tree
   // ---------------------------------------------------------------------------
   ctl_type ctl_ff [PIPE];
   ctl_type ctl_in;

   always_comb begin
      ctl_in.acc   = acc_go;
      ctl_in.rd    = req_fire && is_read;
      ctl_in.rd_ok = (CMP_W'(req_ch.read_address) < CMP_W'(OUT_DEPTH));
      ctl_in.addr  = acc_go ? AW'(target) : AW'(req_ch.read_address);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < PIPE; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Accumulation memory: read at R_ST, add and write back at W_ST
   // ---------------------------------------------------------------------------
   logic [VAL_W-1:0] sum_mem [OUT_DEPTH];
   logic [VAL_W-1:0] rdata_ff;
   logic             byp_hit_ff, byp_hit_in;
   logic [VAL_W-1:0] byp_data_ff, byp_data_in;
   logic             clr_ff, clr_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [VAL_W-1:0] old_val, sat_val;
   logic [SC_W-1:0]  scaled;
   logic [VAL_W:0]   sum_x;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [VAL_W-1:0] mem_wdata;

   always_comb begin
      // the registered read of this entry may predate the write back of the item ahead
      old_val = byp_hit_ff ? byp_data_ff : rdata_ff;
      // drop the 16 fraction bits: floor for negative sums too
      scaled  = root[ACC_W-1:FRAC_SHIFT];
      sum_x   = {old_val[VAL_W-1], old_val} +
                {{(VAL_W + 1 - SC_W){scaled[SC_W-1]}}, scaled};
      if (sum_x[VAL_W] != sum_x[VAL_W-1]) begin
         sat_val = sum_x[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat_val = sum_x[VAL_W-1:0];
      end

      byp_hit_in  = ctl_ff[W_ST].acc && (ctl_ff[W_ST].addr == ctl_ff[R_ST].addr);
      byp_data_in = sat_val;

      mem_we    = clr_ff || ctl_ff[W_ST].acc;
      mem_waddr = clr_ff ? clr_addr_ff : ctl_ff[W_ST].addr;
      mem_wdata = clr_ff ? '0 : sat_val;

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(OUT_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= sum_mem[ctl_ff[R_ST].addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         byp_hit_ff  <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         byp_hit_ff  <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
   end

   // ---------------------------------------------------------------------------
   // Read responses and the credit count that guards the queue
   // ---------------------------------------------------------------------------
   logic             q_push, rsp_pop;
   logic [VAL_W-1:0] q_data;
   logic [CRD_W-1:0] credit_ff, credit_in;

   assign q_push = ctl_ff[W_ST].rd;
   assign q_data = ctl_ff[W_ST].rd_ok ? old_val : '0;

   fdfa_rsp_queue #(
      .DEPTH (QDEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (rsp_pop),
      .rsp_ch    (rsp_ch)
   );

   // every read in the pipeline or the queue holds one credit
   assign in_ready  = !clr_ff && (credit_ff < CRD_W'(QDEPTH));
   assign credit_in = credit_ff + CRD_W'(req_fire && is_read) - CRD_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !(ctl_ff[W_ST].acc || ctl_ff[W_ST].rd || ctl_ff[R_ST].acc))
      else $error("accumulation pipeline active during memory clear");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRD_W'(QDEPTH))
      else $error("response credits exceed queue depth");

   a_credit_take: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_read && !rsp_pop) |=> (credit_ff == $past(credit_ff) + 1'b1))
      else $error("read command did not take a credit");

   a_bypass_source: assert property (@(posedge clock) disable iff (reset)
      byp_hit_ff |-> $past(ctl_ff[W_ST].acc))
      else $error("forwarded data without a write back");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_push && !req_ch.restart && (count_ff == CNT_MAX))
      |=> (count_ff == CNT_MAX))
      else $error("sample counter left its maximum without restart");
`endif

endmodule

// ----- design/fdfa_mac.sv -----
// Tap multipliers and registered adder tree for one window of the delay line.
// Depends on fdfa_pkg for sample and coefficient widths.
module fdfa_mac #(
   parameter int TAPS = fdfa_pkg::TAPS_DEF
) (
   input  logic                                                   clock,
   input  logic signed [fdfa_pkg::SMP_W-1:0]                      window [TAPS],
   input  logic signed [fdfa_pkg::COEF_W-1:0]                     taps [TAPS],
   output logic signed [fdfa_pkg::SMP_W+fdfa_pkg::COEF_W+$clog2(TAPS)-1:0] root
);
   import fdfa_pkg::*;

   localparam int LEVELS = $clog2(TAPS);
   localparam int NPAD   = 1 << LEVELS;
   localparam int PROD_W = SMP_W + COEF_W;
   localparam int ACC_W  = PROD_W + LEVELS;

   logic signed [PROD_W-1:0] prod [TAPS];
   // heap order: node 1 is the root, leaves start at NPAD
   logic signed [ACC_W-1:0]  node_ff [1:2*NPAD-1];
   logic signed [ACC_W-1:0]  node_in [1:2*NPAD-1];

   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         prod[j] = window[j] * taps[j];
      end
   end

   always_comb begin
      for (int k = 1; k < NPAD; k++) begin
         node_in[k] = node_ff[2*k] + node_ff[2*k+1];
      end
      for (int j = 0; j < NPAD; j++) begin
         if (j < TAPS) begin
            node_in[NPAD+j] = ACC_W'(prod[j]);
         end else begin
            node_in[NPAD+j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < 2*NPAD; k++) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[1];

endmodule

// ----- design/fdfa_rsp_queue.sv -----
// Result queue between the accumulation pipeline and the response channel.
// Depends on fdfa_pkg and fdfa_rsp_if.
module fdfa_rsp_queue #(
   parameter int DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [fdfa_pkg::VAL_W-1:0]  push_data,
   output logic                        pop,
   fdfa_rsp_if.source                  rsp_ch
);
   import fdfa_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [VAL_W-1:0]  entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign rsp_ch.valid      = (fill_ff != '0);
   assign rsp_ch.read_value = $signed(entries_ff[rd_ptr_ff]);
   assign pop               = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
